[rtl/core/plist_pkg.sv]
// Shared widths and cell control types for the positional list engine.
// No dependencies; every other file of the block imports this package.
package plist_pkg;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;
  localparam int LENGTH_W = 7;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROT_LEFT,
    CELL_ROT_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [INDEX_W-1:0]   idx;
  } cell_ctrl_t;

endpackage

[rtl/core/plist_in_if.sv]
// Input channel of the positional list engine: valid, ready and one command.
// Depends on plist_pkg for the field widths.
interface plist_in_if;
  import plist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

[rtl/core/plist_out_if.sv]
// Result channel of the positional list engine: valid, ready and one result.
// Depends on plist_pkg for the field widths.
interface plist_out_if;
  import plist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] element_value;
  logic [INDEX_W-1:0]       element_index;
  logic [LENGTH_W-1:0]      list_length;
  logic                     last;

  modport source (output valid, output status, output element_value, output element_index,
                  output list_length, output last, input ready);
  modport sink   (input valid, input status, input element_value, input element_index,
                  input list_length, input last, output ready);
endinterface

[rtl/core/plist_cell.sv]
// One storage cell of the list chain: holds an element and takes a value from
// a neighbour, the new value or the wrap bus. Depends on plist_pkg.
module plist_cell #(
  parameter int INDEX      = 0,
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  plist_pkg::cell_ctrl_t   ctrl,
  input  logic [VALUE_BITS-1:0]   left,
  input  logic [VALUE_BITS-1:0]   right,
  input  logic [VALUE_BITS-1:0]   fresh,
  input  logic [VALUE_BITS-1:0]   wrap,
  output logic [VALUE_BITS-1:0]   q
);
  import plist_pkg::*;

  localparam logic [INDEX_W-1:0] POS = INDEX_W'(INDEX);

  logic [VALUE_BITS-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (POS == ctrl.idx) begin
          q_next = fresh;
        end else if (POS > ctrl.idx) begin
          q_next = left;
        end
      end
      CELL_REMOVE: begin
        if (POS >= ctrl.idx) begin
          q_next = right;
        end
      end
      CELL_ROT_LEFT: begin
        if (POS == ctrl.idx) begin
          q_next = wrap;
        end else if (POS < ctrl.idx) begin
          q_next = right;
        end
      end
      CELL_ROT_RIGHT: begin
        if (POS == '0) begin
          q_next = wrap;
        end else if (POS <= ctrl.idx) begin
          q_next = left;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: control sequencer, result register
// and the chain of plist_cell storage cells. Depends on plist_pkg and the two channel interfaces.
//
// Commands arrive on the items channel and results leave on the results channel; each
// transfer takes place when valid and ready are both high. An insert or a remove updates
// the whole cell chain at once, each cell taking its neighbour's value, and loads one
// result into the output register. A listing of N elements gives N results, one per cycle
// while the receiver keeps up, as the chain rotates by one place per step and the front
// or back cell is read out; an empty listing gives one status result. A new command is
// taken only once the previous command's final result has been loaded, so an insert or
// remove sustains one command per cycle while results are taken, and a listing occupies
// the block until its last result is loaded. When the receiver stalls the result register
// holds its contents and no further command or listing step is taken. Reset empties the
// list and drops any pending result; cell contents stay and are never read before being written.
module positional_list_engine #(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  plist_in_if.sink    items,
  plist_out_if.source results
);
  import plist_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FIRST = 3'd0,
    MODE_INS_LAST  = 3'd1,
    MODE_INS_AT    = 3'd2,
    MODE_REMOVE    = 3'd3,
    MODE_LIST_FWD  = 3'd4,
    MODE_LIST_REV  = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_PAST_END = 3'd2,
    ST_FULL     = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  typedef enum logic {S_IDLE, S_LIST} state_t;

  state_t                state;
  logic [LENGTH_W-1:0]   count;
  logic [INDEX_W-1:0]    list_idx;
  logic                  list_rev;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [DATA_W-1:0]     out_value;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_last;

  logic [VALUE_BITS-1:0] cell_q [CAPACITY];
  logic [VALUE_BITS-1:0] fresh;
  logic [VALUE_BITS-1:0] wrap;
  logic [VALUE_BITS-1:0] tail;
  logic [VALUE_BITS-1:0] pick;
  logic signed [63:0]    value_wide;
  logic signed [63:0]    pick_wide;
  logic [DATA_W-1:0]     elem;
  logic [LENGTH_W-1:0]   tail_pos;
  logic [LENGTH_W-1:0]   pos_ext;
  logic [LENGTH_W-1:0]   count_next;
  cell_ctrl_t            ctrl;
  status_t               status_next;
  logic                  out_free;
  logic                  accept;
  logic                  step;
  logic                  reverse;
  logic                  listing;
  logic                  last_next;
  logic                  start_list;

  assign out_free     = results.ready || !out_valid;
  assign items.ready  = !rst && (state == S_IDLE) && out_free;
  assign accept       = items.valid && items.ready;
  assign step         = (state == S_LIST) && out_free;

  assign value_wide = 64'(items.value);
  assign fresh      = value_wide[VALUE_BITS-1:0];
  assign tail_pos   = count - LENGTH_W'(1);
  assign tail       = cell_q[tail_pos[IW-1:0]];
  assign pos_ext    = LENGTH_W'(items.position);

  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.idx    = '0;
    status_next = ST_OK;
    count_next  = count;
    reverse     = list_rev;
    listing     = 1'b0;
    last_next   = 1'b1;
    start_list  = 1'b0;
    if (accept) begin
      unique case (items.mode)
        MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_AT: begin
          if (items.mode == MODE_INS_AT && items.position == '0) begin
            status_next = ST_ZERO;
          end else if (count >= LENGTH_W'(CAPACITY)) begin
            status_next = ST_FULL;
          end else begin
            ctrl.op    = CELL_INSERT;
            count_next = count + LENGTH_W'(1);
            if (items.mode == MODE_INS_FIRST) begin
              ctrl.idx = '0;
            end else if (items.mode == MODE_INS_LAST || pos_ext > count) begin
              ctrl.idx = count[INDEX_W-1:0];
            end else begin
              ctrl.idx = items.position - INDEX_W'(1);
            end
          end
        end
        MODE_REMOVE: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else if (items.position == '0) begin
            status_next = ST_ZERO;
          end else if (pos_ext > count) begin
            status_next = ST_PAST_END;
          end else begin
            ctrl.op    = CELL_REMOVE;
            ctrl.idx   = items.position - INDEX_W'(1);
            count_next = count - LENGTH_W'(1);
          end
        end
        MODE_LIST_FWD, MODE_LIST_REV: begin
          reverse = (items.mode == MODE_LIST_REV);
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            listing    = 1'b1;
            ctrl.op    = reverse ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
            ctrl.idx   = tail_pos[INDEX_W-1:0];
            last_next  = (count == LENGTH_W'(1));
            start_list = !last_next;
          end
        end
        default: status_next = ST_OK;
      endcase
    end else if (step) begin
      listing   = 1'b1;
      ctrl.op   = reverse ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
      ctrl.idx  = tail_pos[INDEX_W-1:0];
      last_next = (LENGTH_W'(list_idx) + LENGTH_W'(1) == count);
    end
  end

  always_comb begin
    pick      = reverse ? tail : cell_q[0];
    wrap      = pick;
    pick_wide = 64'($signed(pick));
    elem      = pick_wide[DATA_W-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left;
    logic [VALUE_BITS-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_right
      assign right = cell_q[i+1];
    end
    plist_cell #(
      .INDEX      (i),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .fresh (fresh),
      .wrap  (wrap),
      .q     (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      list_idx  <= '0;
      list_rev  <= 1'b0;
    end else begin
      if (accept) begin
        out_valid  <= 1'b1;
        out_status <= status_next;
        out_value  <= listing ? elem : '0;
        out_index  <= '0;
        out_last   <= last_next;
        count      <= count_next;
        list_rev   <= reverse;
        list_idx   <= INDEX_W'(1);
        if (start_list) begin
          state <= S_LIST;
        end
      end else if (step) begin
        out_valid  <= 1'b1;
        out_status <= ST_OK;
        out_value  <= elem;
        out_index  <= list_idx;
        out_last   <= last_next;
        list_idx   <= list_idx + INDEX_W'(1);
        if (last_next) begin
          state <= S_IDLE;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid         = out_valid;
  assign results.status        = out_status;
  assign results.element_value = out_value;
  assign results.element_index = out_index;
  assign results.list_length   = count;
  assign results.last          = out_last;
endmodule
